>>> rtl/core/sdda_pkg.sv
// Package for the scaled DDA line rasterizer: sequencer states, command codes,
// configuration register indexes and fixed field widths.
// No dependencies; compiled before every other file of the block.
package sdda_pkg;

  // Fixed widths of the configuration registers and the write port.
  localparam int SCALE_BITS     = 16;
  localparam int TRANS_BITS     = 12;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_X     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_Y     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSLATE_X = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSLATE_Y = 3'd3;

  // Register reset values.
  localparam logic [SCALE_BITS-1:0] SCALE_ONE = 16'd256;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Transform sequencing: four coordinates through a two-stage unit.
  localparam logic [2:0] XF_LAT      = 3'd2;
  localparam logic [2:0] XF_LAST_CNT = 3'd5;

  // Edge setup sequencer.
  typedef enum logic [2:0] {
    S_IDLE,
    S_XFORM,
    S_DELTA,
    S_DIVX,
    S_DIVY
  } state_t;

endpackage

>>> rtl/core/sdda_in_if.sv
// Input channel of the line rasterizer: valid/ready handshake with one
// load or step command per transaction. Depends on nothing.
interface sdda_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (output valid, command, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, command, x_start, y_start, x_end, y_end, output ready);
endinterface

>>> rtl/core/sdda_out_if.sv
// Result channel of the line rasterizer: valid/ready handshake with one
// plotted point per transaction. Depends on nothing.
interface sdda_out_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

>>> rtl/core/sdda_xform.sv
// Shared coordinate transform unit: multiply by a Q8.8 scale, add the offset,
// round half away from zero and saturate. Two stages. Uses sdda_pkg.
module sdda_xform #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic signed [COORD_BITS-1:0]         coord_i,
  input  logic [sdda_pkg::SCALE_BITS-1:0]      scale_i,
  input  logic signed [sdda_pkg::TRANS_BITS-1:0] trans_i,
  output logic signed [COORD_BITS-1:0]         result_o
);
  import sdda_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int PW = C + SCALE_BITS + 1;
  localparam int W  = PW + 1;
  localparam int QW = W - 8;
  localparam logic [QW-1:0] POS_LIM = QW'((1 << (C - 1)) - 1);
  localparam logic [QW-1:0] NEG_LIM = QW'(1 << (C - 1));
  localparam logic signed [C-1:0] C_MAX = C'((1 << (C - 1)) - 1);
  localparam logic signed [C-1:0] C_MIN = C'(1 << (C - 1));

  logic signed [PW-1:0]         prod_nxt;
  logic signed [PW-1:0]         prod_r;
  logic signed [TRANS_BITS-1:0] trans_r;
  logic signed [W-1:0]          sum;
  logic [W-1:0]                 mag;
  logic [W-1:0]                 mag_rnd;
  logic [QW-1:0]                q;
  logic signed [C-1:0]          res_nxt;
  logic signed [C-1:0]          res_r;

  // Stage one: the product of coordinate and unsigned scale.
  assign prod_nxt = coord_i * $signed({1'b0, scale_i});

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    trans_r <= trans_i;
  end

  // Stage two: add the offset in Q8.8, round the magnitude, saturate.
  always_comb begin
    sum     = W'(prod_r) + W'($signed({trans_r, 8'b0}));
    mag     = sum[W-1] ? -sum : sum;
    mag_rnd = mag + W'(128);
    q       = mag_rnd[W-1:8];
    if (!sum[W-1]) begin
      res_nxt = (q > POS_LIM) ? C_MAX : q[C-1:0];
    end else begin
      res_nxt = (q > NEG_LIM) ? C_MIN : -q[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign result_o = res_r;

endmodule

>>> rtl/core/sdda_div.sv
// Restoring divider for the per-step increments: (num << FRAC_BITS) / den
// with num <= den, one quotient bit per cycle. Uses sdda_pkg for style only.
module sdda_div #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] num_i,
  input  logic [COORD_BITS-1:0] den_i,
  output logic                  done_o,
  output logic [FRAC_BITS:0]    quot_o
);
  import sdda_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int CW = $clog2(F + 2);
  localparam logic [CW-1:0] ITER = CW'(F + 1);

  logic [CW-1:0] cnt_r;
  logic [C:0]    rem_r;
  logic [C-1:0]  den_r;
  logic [F:0]    quot_r;
  logic          done_r;
  logic          busy;
  logic          ge;
  logic [C:0]    diff;

  assign busy = (cnt_r != '0);

  // One restoring step: compare, conditionally subtract, shift.
  always_comb begin
    ge   = (rem_r >= {1'b0, den_r});
    diff = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  end

  // Iteration counter and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (cnt_r == CW'(1));
      if (start_i) begin
        cnt_r <= ITER;
      end else if (busy) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Remainder and quotient datapath.
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r  <= {1'b0, num_i};
      den_r  <= den_i;
      quot_r <= '0;
    end else if (busy) begin
      rem_r  <= {diff[C-1:0], 1'b0};
      quot_r <= {quot_r[F-1:0], ge};
    end
  end

  assign done_o = done_r;
  assign quot_o = quot_r;

endmodule

>>> rtl/core/scaled_dda_line_rasterizer_unit.sv
// Scaled DDA line rasterizer, top level.
// Depends on sdda_pkg, sdda_in_if, sdda_out_if, sdda_xform and sdda_div.
//
// Usage: the input channel carries commands. A load transaction brings the
// two endpoints of an edge; they are scaled by the Q8.8 factors, offset,
// rounded half away from zero and saturated, and the per-step increments
// are divided out. A load gives no result. Each step transaction then gives
// the next rounded point on the result channel, with last_point set on the
// edge's final point; a step with no edge active gives nothing. A load in
// the middle of an edge replaces it.
// After a load transaction ready stays low for the four passes through the
// shared transform unit and the two passes through the bit-serial divider.
// A step's point is registered and shown the cycle after the step is taken.
// The output register lets a step be taken while the previous point is
// being taken in the same cycle; while the receiver stalls, ready stays low
// and the point holds. Configuration is written through cfg_we, cfg_index and
// cfg_wdata; the user must write it only while the block is idle, and the
// block itself does not enforce this. Synchronous reset loads the default
// registers (scale one, no offset) and drops any edge.
module scaled_dda_line_rasterizer_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sdda_in_if.sink                             in_if,
  sdda_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [sdda_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sdda_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import sdda_pkg::*;

  localparam int C = COORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int P = C + F + 1;
  localparam logic [C+1:0] POS_LIM = (C+2)'((1 << (C - 1)) - 1);
  localparam logic [C+1:0] NEG_LIM = (C+2)'(1 << (C - 1));
  localparam logic signed [C-1:0] C_MAX = C'((1 << (C - 1)) - 1);
  localparam logic signed [C-1:0] C_MIN = C'(1 << (C - 1));
  localparam logic [P:0] HALF = (P+1)'(1) << (F - 1);

  // Round a position half away from zero and saturate it to a coordinate.
  function automatic logic signed [C-1:0] rnd_sat(input logic signed [P-1:0] v);
    logic [P-1:0] mag;
    logic [P:0]   sum;
    logic [C+1:0] q;
    mag = v[P-1] ? -v : v;
    sum = {1'b0, mag} + HALF;
    q   = sum[P:F];
    if (!v[P-1]) begin
      rnd_sat = (q > POS_LIM) ? C_MAX : q[C-1:0];
    end else begin
      rnd_sat = (q > NEG_LIM) ? C_MIN : -q[C-1:0];
    end
  endfunction

  state_t state_r, state_nxt;

  logic [SCALE_BITS-1:0]        scale_x_r, scale_y_r;
  logic signed [TRANS_BITS-1:0] trans_x_r, trans_y_r;

  logic signed [C-1:0] raw_r [0:3];
  logic signed [C-1:0] coord_r [0:3];
  logic [2:0]          xf_cnt_r;
  logic [1:0]          xf_wr_idx;
  logic signed [C-1:0] xf_res;

  logic signed [P-1:0] pos_x_r, pos_y_r, step_x_r, step_y_r;
  logic [C:0]          points_left_r;
  logic                edge_active_r;
  logic [C-1:0]        ay_r, steps_r;
  logic                neg_x_r, neg_y_r;

  logic                out_valid_r;
  logic signed [C-1:0] point_x_r, point_y_r;
  logic                last_r;

  logic                in_ready, in_acc, load_go, step_emit;
  logic                div_start, div_done;
  logic [C-1:0]        div_num, div_den;
  logic [F:0]          div_quot;
  logic signed [C:0]   dx, dy, adx, ady;
  logic [C-1:0]        ax, ay, steps_c;
  logic [P-1:0]        q_ext, step_val;
  logic                xf_capture;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= SCALE_ONE;
      scale_y_r <= SCALE_ONE;
      trans_x_r <= '0;
      trans_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_X:     scale_x_r <= cfg_wdata[SCALE_BITS-1:0];
        REG_SCALE_Y:     scale_y_r <= cfg_wdata[SCALE_BITS-1:0];
        REG_TRANSLATE_X: trans_x_r <= cfg_wdata[TRANS_BITS-1:0];
        REG_TRANSLATE_Y: trans_y_r <= cfg_wdata[TRANS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake decode.
  assign in_acc    = in_if.valid && in_ready;
  assign load_go   = in_acc && (in_if.command == CMD_LOAD);
  assign step_emit = in_acc && (in_if.command == CMD_STEP) && edge_active_r &&
                     (points_left_r != '0);

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (load_go) state_nxt = S_XFORM;
      S_XFORM: if (xf_cnt_r == XF_LAST_CNT) state_nxt = S_DELTA;
      S_DELTA: state_nxt = S_DIVX;
      S_DIVX:  if (div_done) state_nxt = S_DIVY;
      S_DIVY:  if (div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    xf_capture = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = !out_valid_r || out_if.ready;
      S_XFORM: xf_capture = (xf_cnt_r >= XF_LAT);
      S_DELTA: div_start = 1'b1;
      S_DIVX:  div_start = div_done;
      S_DIVY:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Transform pass counter; coordinates go through in load order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xf_cnt_r <= '0;
    end else if (load_go) begin
      xf_cnt_r <= '0;
    end else if (state_r == S_XFORM) begin
      xf_cnt_r <= xf_cnt_r + 3'd1;
    end
  end

  // Raw endpoints held for the transform passes.
  always_ff @(posedge clk) begin
    if (load_go) begin
      raw_r[0] <= in_if.x_start;
      raw_r[1] <= in_if.y_start;
      raw_r[2] <= in_if.x_end;
      raw_r[3] <= in_if.y_end;
    end
  end

  sdda_xform #(
    .COORD_BITS (C)
  ) u_xform (
    .clk      (clk),
    .coord_i  (raw_r[xf_cnt_r[1:0]]),
    .scale_i  (xf_cnt_r[0] ? scale_y_r : scale_x_r),
    .trans_i  (xf_cnt_r[0] ? trans_y_r : trans_x_r),
    .result_o (xf_res)
  );

  // Transformed endpoints come back through the product and result registers of the transform unit.
  assign xf_wr_idx = 2'(xf_cnt_r - XF_LAT);

  always_ff @(posedge clk) begin
    if (xf_capture) begin
      coord_r[xf_wr_idx] <= xf_res;
    end
  end

  // Deltas and step count from the transformed endpoints.
  always_comb begin
    dx      = (C+1)'(coord_r[2]) - (C+1)'(coord_r[0]);
    dy      = (C+1)'(coord_r[3]) - (C+1)'(coord_r[1]);
    adx     = dx[C] ? -dx : dx;
    ady     = dy[C] ? -dy : dy;
    ax      = adx[C-1:0];
    ay      = ady[C-1:0];
    steps_c = (ax > ay) ? ax : ay;
  end

  // Divider operands: x in the setup cycle, y when the x result lands.
  assign div_num = (state_r == S_DELTA) ? ax : ay_r;
  assign div_den = (state_r == S_DELTA) ? steps_c : steps_r;

  sdda_div #(
    .COORD_BITS (C),
    .FRAC_BITS  (F)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Signed increment from the quotient; a zero-length edge does not move.
  always_comb begin
    q_ext = P'(div_quot);
    if (steps_r == '0) begin
      step_val = '0;
    end else begin
      step_val = (state_r == S_DIVX ? neg_x_r : neg_y_r) ? -q_ext : q_ext;
    end
  end

  // Edge datapath: setup values, increments and stepping.
  always_ff @(posedge clk) begin
    if (state_r == S_DELTA) begin
      pos_x_r <= P'(coord_r[0]) << F;
      pos_y_r <= P'(coord_r[1]) << F;
      ay_r    <= ay;
      steps_r <= steps_c;
      neg_x_r <= dx[C];
      neg_y_r <= dy[C];
    end else if (step_emit) begin
      pos_x_r <= pos_x_r + step_x_r;
      pos_y_r <= pos_y_r + step_y_r;
    end
    if (state_r == S_DIVX && div_done) begin
      step_x_r <= step_val;
    end
    if (state_r == S_DIVY && div_done) begin
      step_y_r <= step_val;
    end
  end

  // Edge control: remaining points and the active flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_left_r <= '0;
      edge_active_r <= 1'b0;
    end else if (state_r == S_DELTA) begin
      points_left_r <= {1'b0, steps_c} + (C+1)'(1);
      edge_active_r <= 1'b1;
    end else if (step_emit) begin
      points_left_r <= points_left_r - (C+1)'(1);
      if (points_left_r == (C+1)'(1)) begin
        edge_active_r <= 1'b0;
      end
    end else if (in_acc && in_if.command == CMD_STEP) begin
      edge_active_r <= 1'b0;
    end
  end

  // Output register: filled by a step, emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_emit) begin
      point_x_r <= rnd_sat(pos_x_r);
      point_y_r <= rnd_sat(pos_y_r);
      last_r    <= (points_left_r == (C+1)'(1));
    end
  end

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid_r;
  assign out_if.point_x    = point_x_r;
  assign out_if.point_y    = point_y_r;
  assign out_if.last_point = last_r;

endmodule

>>> rtl/core/sdda_checker.sv
// Port-level checker for the scaled DDA line rasterizer and its bind.
// Depends on sdda_pkg and scaled_dda_line_rasterizer_unit.
module sdda_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_command,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] point_x,
  input logic [COORD_BITS-1:0] point_y,
  input logic                  last_point
);
  import sdda_pkg::*;

  // A point that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  // A stalled point keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(point_x) && $stable(point_y) &&
    $stable(last_point))
    else $error("result payload changed while stalled");

  // Edge setup takes the block off the input channel.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_LOAD) |=> !in_ready)
    else $error("input ready right after a load transaction");

  // A new point only follows an accepted step command.
  a_point_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_command == CMD_STEP)))
    else $error("result transaction without a step command");

endmodule

bind scaled_dda_line_rasterizer_unit sdda_checker #(
  .COORD_BITS (COORD_BITS)
) u_sdda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .in_command (in_if.command),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .point_x    (out_if.point_x),
  .point_y    (out_if.point_y),
  .last_point (out_if.last_point)
);
